>>> design/vlnl_pkg.sv
`timescale 1ns / 1ps
package vlnl_pkg;

  localparam int CompWidth = 16;
  localparam int SumWidth  = 2 * CompWidth + 1;
  localparam int RootWidth = CompWidth + 1;
  localparam int QuotWidth = CompWidth - 1;
  localparam int MagWidth  = 17;
  localparam int BlendWidth = 9;
  localparam int Lanes = 4;

  localparam logic [1:0] MODE_LENGTH = 2'd0;
  localparam logic [1:0] MODE_NORM   = 2'd1;
  localparam logic [1:0] MODE_LERP   = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  // Per-item information that rides alongside the square root and divider.
  typedef struct packed {
    logic [1:0]                             mode;
    logic [Lanes-1:0][CompWidth-1:0]        mag_a;
    logic [Lanes-1:0]                       neg;
    logic signed [Lanes-1:0][CompWidth-1:0] lerp;
  } side_t;

endpackage

>>> design/vlnl_if.sv
`timescale 1ns / 1ps
interface vlnl_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              mode;
  logic signed [vlnl_pkg::CompWidth-1:0]   comp_x;
  logic signed [vlnl_pkg::CompWidth-1:0]   comp_y;
  logic signed [vlnl_pkg::CompWidth-1:0]   comp_z;
  logic signed [vlnl_pkg::CompWidth-1:0]   comp_w;
  logic signed [vlnl_pkg::CompWidth-1:0]   dest_x;
  logic signed [vlnl_pkg::CompWidth-1:0]   dest_y;
  logic signed [vlnl_pkg::CompWidth-1:0]   dest_z;
  logic signed [vlnl_pkg::CompWidth-1:0]   dest_w;
  logic [vlnl_pkg::BlendWidth-1:0]         blend;

  modport source (output valid, mode, comp_x, comp_y, comp_z, comp_w,
                  dest_x, dest_y, dest_z, dest_w, blend, input ready);
  modport sink (input valid, mode, comp_x, comp_y, comp_z, comp_w,
                dest_x, dest_y, dest_z, dest_w, blend, output ready);
endinterface

interface vlnl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [15:0]                  res_x;
  logic signed [15:0]                  res_y;
  logic signed [15:0]                  res_z;
  logic signed [15:0]                  res_w;
  logic [vlnl_pkg::MagWidth-1:0]       magnitude;
  logic                                zero_length;

  modport source (output valid, res_x, res_y, res_z, res_w, magnitude, zero_length,
                  input ready);
  modport sink (input valid, res_x, res_y, res_z, res_w, magnitude, zero_length,
                output ready);
endinterface

>>> design/vec4_length_normalize_lerp.sv
`timescale 1ns / 1ps
// Four-component vector unit: length, normalise, or interpolate.
// Items arrive on the vec_in channel (valid/ready); a transfer carries the
// mode, the vector comp_x..comp_w in signed Q8.8, a destination dest_x..dest_w
// and a Q1.8 blend factor. Each item yields exactly one transfer on res_out:
// the length in unsigned Q9.8 (mode 0), the unit vector in signed Q1.14 with a
// zero_length flag (mode 1), the saturated Q8.8 interpolation (mode 2), or
// all zeros (mode 3). Throughput is one item per cycle: the pipeline length is
// set by the square root, which resolves one root bit per stage (17 stages),
// and the divider, which resolves one quotient bit per stage in four lanes
// (15 stages plus an entry stage for the rounded dividend).
// The whole pipeline advances together whenever the output register is empty
// or being taken; while the receiver stalls, every stage holds and vec_in
// ready is low, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; the data registers are not reset.
module vec4_length_normalize_lerp (
  input  logic       clk,
  input  logic       rst,
  vlnl_in_if.sink    vec_in,
  vlnl_out_if.source res_out
);

  localparam int CW = vlnl_pkg::CompWidth;
  localparam int L  = vlnl_pkg::Lanes;
  localparam int PW = CW + vlnl_pkg::BlendWidth + 2;

  logic en;
  assign en = !res_out.valid || res_out.ready;
  assign vec_in.ready = en;

  // Stage 0: captured input.
  logic                          v0;
  logic [1:0]                    mode0;
  logic signed [L-1:0][CW-1:0]   c0;
  logic signed [L-1:0][CW-1:0]   d0;
  logic [vlnl_pkg::BlendWidth-1:0] blend0;

  // Stage 1: magnitudes, squares and the interpolation products.
  logic                          v1;
  logic [1:0]                    mode1;
  logic [L-1:0][CW-1:0]          a1;
  logic [L-1:0]                  neg1;
  logic signed [L-1:0][CW-1:0]   c1;
  logic [L-1:0][2*CW-1:0]        sq1;
  logic signed [L-1:0][PW-1:0]   prod1;

  // Stage 2: sum of squares and the finished interpolation.
  logic                          v2;
  logic [vlnl_pkg::SumWidth-1:0] sum2;
  vlnl_pkg::side_t               side2;

  logic [L-1:0][CW-1:0]          a_next;
  logic signed [L-1:0][CW-1:0]   lerp_next;
  logic [vlnl_pkg::SumWidth-1:0] sum_next;

  always_comb begin
    logic signed [PW-1:0] shifted;
    logic signed [CW+2:0] total;
    sum_next = '0;
    for (int l = 0; l < L; l++) begin
      a_next[l] = c0[l][CW-1] ? CW'(-c0[l]) : CW'(c0[l]);
      sum_next  = sum_next + vlnl_pkg::SumWidth'(sq1[l]);
      // Adding half and shifting arithmetically rounds halves upwards.
      shifted = $signed(prod1[l] + PW'(128)) >>> 8;
      total   = (CW+3)'($signed(c1[l])) + (CW+3)'(shifted);
      if (total > (CW+3)'(32767)) begin
        lerp_next[l] = 16'sh7fff;
      end else if (total < -(CW+3)'(32768)) begin
        lerp_next[l] = 16'sh8000;
      end else begin
        lerp_next[l] = CW'(total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= vec_in.valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0  <= vec_in.mode;
      c0     <= {vec_in.comp_w, vec_in.comp_z, vec_in.comp_y, vec_in.comp_x};
      d0     <= {vec_in.dest_w, vec_in.dest_z, vec_in.dest_y, vec_in.dest_x};
      blend0 <= vec_in.blend;

      mode1 <= mode0;
      c1    <= c0;
      for (int l = 0; l < L; l++) begin
        a1[l]    <= a_next[l];
        neg1[l]  <= c0[l][CW-1];
        sq1[l]   <= (2*CW)'(a_next[l]) * (2*CW)'(a_next[l]);
        prod1[l] <= PW'($signed({d0[l][CW-1], d0[l]}) - $signed({c0[l][CW-1], c0[l]})) *
                    PW'({1'b0, blend0});
      end

      sum2         <= sum_next;
      side2.mode   <= mode1;
      side2.mag_a  <= a1;
      side2.neg    <= neg1;
      side2.lerp   <= lerp_next;
    end
  end

  logic                              v_sq;
  logic [vlnl_pkg::RootWidth-1:0]    root_sq;
  vlnl_pkg::side_t                   side_sq;

  vlnl_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_sum    (sum2),
    .in_side   (side2),
    .out_valid (v_sq),
    .out_root  (root_sq),
    .out_side  (side_sq)
  );

  logic                                           v_dv;
  logic [L-1:0][vlnl_pkg::QuotWidth-1:0]          quot_dv;
  logic [vlnl_pkg::RootWidth-1:0]                 len_dv;
  vlnl_pkg::side_t                                side_dv;

  vlnl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_sq),
    .in_len    (root_sq),
    .in_side   (side_sq),
    .out_valid (v_dv),
    .out_quot  (quot_dv),
    .out_len   (len_dv),
    .out_side  (side_dv)
  );

  // Result selection. The quotient never exceeds one in Q1.14, since no
  // component is larger than the truncated length.
  logic signed [L-1:0][CW-1:0]   res_next;
  logic [vlnl_pkg::MagWidth-1:0] mag_next;
  logic                          zero_next;

  always_comb begin
    res_next  = '0;
    mag_next  = '0;
    zero_next = 1'b0;
    case (side_dv.mode)
      vlnl_pkg::MODE_LENGTH: begin
        mag_next = vlnl_pkg::MagWidth'(len_dv);
      end
      vlnl_pkg::MODE_NORM: begin
        if (len_dv == '0) begin
          zero_next = 1'b1;
        end else begin
          mag_next = vlnl_pkg::MagWidth'(len_dv);
          for (int l = 0; l < L; l++) begin
            res_next[l] = side_dv.neg[l] ? -CW'(quot_dv[l]) : CW'(quot_dv[l]);
          end
        end
      end
      vlnl_pkg::MODE_LERP: begin
        res_next = side_dv.lerp;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (en) begin
      res_out.valid <= v_dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out.res_x       <= res_next[0];
      res_out.res_y       <= res_next[1];
      res_out.res_z       <= res_next[2];
      res_out.res_w       <= res_next[3];
      res_out.magnitude   <= mag_next;
      res_out.zero_length <= zero_next;
    end
  end

`ifndef SYNTH
  // A zero-length result always carries zeroed components and magnitude.
  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.zero_length |->
      res_out.magnitude == '0 && res_out.res_x == '0 && res_out.res_y == '0 &&
      res_out.res_z == '0 && res_out.res_w == '0)
    else $error("zero_length result with non-zero fields");

  // The length of a Q8.8 four-vector cannot exceed 256.0.
  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> res_out.magnitude <= 17'd65536)
    else $error("magnitude beyond the largest possible length");

  // The pipeline is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_out.valid && !v0 && !v_dv)
    else $error("valid bit survived reset");
`endif

endmodule

>>> design/vlnl_sqrt.sv
`timescale 1ns / 1ps
module vlnl_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [vlnl_pkg::SumWidth-1:0]     in_sum,
  input  vlnl_pkg::side_t                   in_side,
  output logic                              out_valid,
  output logic [vlnl_pkg::RootWidth-1:0]    out_root,
  output vlnl_pkg::side_t                   out_side
);

  localparam int Steps = vlnl_pkg::RootWidth;
  localparam int SW = 2 * Steps;
  localparam int RW = vlnl_pkg::RootWidth + 2;

  logic [Steps-1:0] vld;
  logic [SW-1:0]    sum [Steps];
  logic [RW-1:0]    rem [Steps];
  logic [Steps-1:0] root [Steps];
  vlnl_pkg::side_t  sd [Steps];

  logic [SW-1:0]    p_sum [Steps];
  logic [RW-1:0]    p_rem [Steps];
  logic [Steps-1:0] p_root [Steps];
  logic [RW-1:0]    rem_next [Steps];
  logic [Steps-1:0] root_next [Steps];

  always_comb begin
    p_sum[0]  = SW'(in_sum);
    p_rem[0]  = '0;
    p_root[0] = '0;
    for (int j = 1; j < Steps; j++) begin
      p_sum[j]  = sum[j-1];
      p_rem[j]  = rem[j-1];
      p_root[j] = root[j-1];
    end
  end

  // One result bit per stage, most significant first.
  always_comb begin
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    for (int j = 0; j < Steps; j++) begin
      cur   = {p_rem[j], p_sum[j][2*(Steps-1-j) +: 2]};
      trial = (RW+2)'({p_root[j], 2'b01});
      if (cur >= trial) begin
        rem_next[j]  = RW'(cur - trial);
        root_next[j] = {p_root[j][Steps-2:0], 1'b1};
      end else begin
        rem_next[j]  = cur[RW-1:0];
        root_next[j] = {p_root[j][Steps-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Steps-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < Steps; j++) begin
        sum[j]  <= p_sum[j];
        rem[j]  <= rem_next[j];
        root[j] <= root_next[j];
        sd[j]   <= (j == 0) ? in_side : sd[(j == 0) ? 0 : j-1];
      end
    end
  end

  assign out_valid = vld[Steps-1];
  assign out_root  = root[Steps-1];
  assign out_side  = sd[Steps-1];

endmodule

>>> design/vlnl_div.sv
`timescale 1ns / 1ps
module vlnl_div (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 en,
  input  logic                                                 in_valid,
  input  logic [vlnl_pkg::RootWidth-1:0]                       in_len,
  input  vlnl_pkg::side_t                                      in_side,
  output logic                                                 out_valid,
  output logic [vlnl_pkg::Lanes-1:0][vlnl_pkg::QuotWidth-1:0]  out_quot,
  output logic [vlnl_pkg::RootWidth-1:0]                       out_len,
  output vlnl_pkg::side_t                                      out_side
);

  localparam int Steps = vlnl_pkg::QuotWidth;
  localparam int LW = vlnl_pkg::RootWidth;
  localparam int L = vlnl_pkg::Lanes;
  localparam int CW = vlnl_pkg::CompWidth;
  localparam int NW = CW + Steps;

  // Entry stage: the rounded dividend, split into a starting remainder and the
  // bits still to bring down.
  logic                          e_vld;
  logic [L-1:0][LW-1:0]          e_rem;
  logic [L-1:0][Steps-1:0]       e_low;
  logic [LW-1:0]                 e_len;
  vlnl_pkg::side_t               e_side;
  logic [L-1:0][NW-1:0]          num;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      num[l] = {1'b0, in_side.mag_a[l], (Steps-1)'(0)} + NW'(in_len >> 1);
    end
  end

  logic [Steps-1:0]              vld;
  logic [L-1:0][LW-1:0]          rem [Steps];
  logic [L-1:0][Steps-1:0]       low [Steps];
  logic [L-1:0][Steps-1:0]       quot [Steps];
  logic [LW-1:0]                 len [Steps];
  vlnl_pkg::side_t               sd [Steps];

  logic [L-1:0][LW-1:0]          p_rem [Steps];
  logic [L-1:0][Steps-1:0]       p_low [Steps];
  logic [L-1:0][Steps-1:0]       p_quot [Steps];
  logic [LW-1:0]                 p_len [Steps];
  vlnl_pkg::side_t               p_sd [Steps];
  logic [L-1:0][LW-1:0]          rem_next [Steps];
  logic [L-1:0][Steps-1:0]       quot_next [Steps];

  always_comb begin
    p_rem[0]  = e_rem;
    p_low[0]  = e_low;
    p_quot[0] = '0;
    p_len[0]  = e_len;
    p_sd[0]   = e_side;
    for (int j = 1; j < Steps; j++) begin
      p_rem[j]  = rem[j-1];
      p_low[j]  = low[j-1];
      p_quot[j] = quot[j-1];
      p_len[j]  = len[j-1];
      p_sd[j]   = sd[j-1];
    end
  end

  // Restoring division, one quotient bit per stage in every lane.
  always_comb begin
    logic [LW:0] cur;
    for (int j = 0; j < Steps; j++) begin
      for (int l = 0; l < L; l++) begin
        cur = {p_rem[j][l], p_low[j][l][Steps-1-j]};
        if (cur >= {1'b0, p_len[j]}) begin
          rem_next[j][l]  = LW'(cur - {1'b0, p_len[j]});
          quot_next[j][l] = {p_quot[j][l][Steps-2:0], 1'b1};
        end else begin
          rem_next[j][l]  = cur[LW-1:0];
          quot_next[j][l] = {p_quot[j][l][Steps-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      vld   <= '0;
    end else if (en) begin
      e_vld <= in_valid;
      vld   <= {vld[Steps-2:0], e_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        e_rem[l] <= LW'(num[l][NW-1:Steps]);
        e_low[l] <= num[l][Steps-1:0];
      end
      e_len  <= in_len;
      e_side <= in_side;
      for (int j = 0; j < Steps; j++) begin
        rem[j]  <= rem_next[j];
        low[j]  <= p_low[j];
        quot[j] <= quot_next[j];
        len[j]  <= p_len[j];
        sd[j]   <= p_sd[j];
      end
    end
  end

  assign out_valid = vld[Steps-1];
  assign out_quot  = quot[Steps-1];
  assign out_len   = len[Steps-1];
  assign out_side  = sd[Steps-1];

endmodule
